// ----- design/lav_pkg.sv -----
// Shared types and constants for the look-at view matrix block.
package lav_pkg;

  localparam int CW     = 32;               // coordinate width
  localparam int DW     = 33;               // eye minus target width
  localparam int QDEPTH = 2;                // front-to-back queue depth
  localparam int QPW    = $clog2(QDEPTH);   // queue pointer width

  // One classified job handed from front to back.
  typedef struct packed {
    logic [2:0][CW-1:0] eye;
    logic [2:0][DW-1:0] diff;
    logic               zero;  // eye equals target
  } job_t;

  // Finished matrix, columns of the basis plus translation row.
  typedef struct packed {
    logic [2:0][CW-1:0] rgt;
    logic [2:0][CW-1:0] upv;
    logic [2:0][CW-1:0] fwd;
    logic [2:0][CW-1:0] trn;
    logic               degen;
  } mat_t;

  typedef struct packed {
    logic done;
    logic ok;
  } norm_sts_t;

  typedef enum logic [2:0] {
    N_IDLE, N_SHIFT, N_SQ, N_SQRT, N_DLOAD, N_DIV
  } norm_state_t;

  typedef enum logic [2:0] {
    C_IDLE, C_NORM_F, C_NORM_R, C_MUL, C_ACC, C_FIN, C_WRITE
  } core_state_t;

endpackage

// ----- design/lav_front.sv -----
// Input stage: takes a word, forms eye minus target and flags a zero view.
module lav_front
  import lav_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [31:0] eye_x,
  input  logic signed [31:0] eye_y,
  input  logic signed [31:0] eye_z,
  input  logic signed [31:0] target_x,
  input  logic signed [31:0] target_y,
  input  logic signed [31:0] target_z,
  output logic               q_valid,
  input  logic               q_ready,
  output job_t               q_data
);

  logic fv;
  job_t word;
  job_t word_next;

  assign in_ready = !fv || q_ready;
  assign q_valid  = fv;
  assign q_data   = word;

  always_comb begin
    word_next.eye[0]  = eye_x;
    word_next.eye[1]  = eye_y;
    word_next.eye[2]  = eye_z;
    word_next.diff[0] = DW'(eye_x) - DW'(target_x);
    word_next.diff[1] = DW'(eye_y) - DW'(target_y);
    word_next.diff[2] = DW'(eye_z) - DW'(target_z);
    word_next.zero    = (eye_x == target_x) && (eye_y == target_y) && (eye_z == target_z);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fv <= 1'b0;
    end else if (in_ready) begin
      fv <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      word <= word_next;
    end
  end

endmodule

// ----- design/lav_queue.sv -----
// Short job queue between the front and the compute back end.
module lav_queue
  import lav_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic wr_valid,
  output logic wr_ready,
  input  job_t wr_data,
  output logic rd_valid,
  input  logic rd_ready,
  output job_t rd_data
);

  job_t                    mem [QDEPTH];
  logic [QPW-1:0]          wp;
  logic [QPW-1:0]          rp;
  logic [$clog2(QDEPTH+1)-1:0] cnt;
  logic                    wr_fire;
  logic                    rd_fire;

  assign wr_ready = (cnt != $bits(cnt)'(QDEPTH));
  assign rd_valid = (cnt != '0);
  assign rd_data  = mem[rp];
  assign wr_fire  = wr_valid && wr_ready;
  assign rd_fire  = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= '0;
      rp  <= '0;
      cnt <= '0;
    end else begin
      if (wr_fire) wp <= wp + 1'b1;
      if (rd_fire) rp <= rp + 1'b1;
      if (wr_fire && !rd_fire) begin
        cnt <= cnt + 1'b1;
      end else if (rd_fire && !wr_fire) begin
        cnt <= cnt - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_fire) begin
      mem[wp] <= wr_data;
    end
  end

endmodule

// ----- design/lav_norm.sv -----
// Vector normalize unit: scale, sum of squares, bit-serial sqrt and divide.
module lav_norm
  import lav_pkg::*;
#(
  parameter int FRAC_BITS = 16
)
(
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [2:0][DW-1:0]        vin,
  output norm_sts_t                 sts,
  output logic [2:0][FRAC_BITS+1:0] vout
);

  localparam int VW  = FRAC_BITS + 2;
  localparam int NDW = 31 + FRAC_BITS;  // dividend width
  localparam int SW  = 63;
  localparam int MW  = DW;

  norm_state_t state, state_next;

  logic [2:0]           neg;
  logic [2:0][MW-1:0]   mag;
  logic [MW-1:0]        mx;
  logic [1:0]           idx;
  logic [SW-1:0]        rem_n;
  logic [SW-1:0]        res;
  logic [SW-1:0]        bitv;
  logic [59:0]          prod;
  logic [NDW-1:0]       dvd;
  logic [30:0]          rem;
  logic [VW-1:0]        quo;
  logic [$clog2(NDW)-1:0] cnt;
  logic                 done;
  logic                 ok_r;

  logic [2:0]           vin_neg;
  logic [2:0][MW-1:0]   vin_mag;
  logic [MW-1:0]        vin_max;

  // decoded controls
  logic                 shr;
  logic                 shl;
  logic [1:0]           sq_sel;
  logic [SW-1:0]        trial_s;
  logic                 take_s;
  logic [31:0]          trial_d;
  logic                 take_d;
  logic [VW-1:0]        q_new;
  logic                 div_end;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      vin_neg[i] = vin[i][DW-1];
      vin_mag[i] = vin_neg[i] ? MW'(~vin[i] + 1'b1) : MW'(vin[i]);
    end
    vin_max = (vin_mag[0] > vin_mag[1]) ? vin_mag[0] : vin_mag[1];
    if (vin_mag[2] > vin_max) vin_max = vin_mag[2];
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      N_IDLE:  if (start && (vin_max != '0)) state_next = N_SHIFT;
      N_SHIFT: if (!shr && !shl) state_next = N_SQ;
      N_SQ:    if (idx == 2'd3) state_next = N_SQRT;
      N_SQRT:  if (bitv[0]) state_next = N_DLOAD;
      N_DLOAD: state_next = N_DIV;
      N_DIV:   if (div_end) state_next = (idx == 2'd2) ? N_IDLE : N_DLOAD;
      default: state_next = N_IDLE;
    endcase
  end

  // outputs and datapath controls
  always_comb begin
    shr     = |mx[MW-1:30];
    shl     = !shr && !mx[29];
    sq_sel  = (idx == 2'd3) ? 2'd0 : idx;
    trial_s = res + bitv;
    take_s  = (rem_n >= trial_s);
    trial_d = {rem, dvd[NDW-1]};
    take_d  = (trial_d >= {1'b0, res[30:0]});
    q_new   = {quo[VW-2:0], take_d};
    div_end = (state == N_DIV) && (cnt == '0);
    sts.done = done;
    sts.ok   = ok_r;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= N_IDLE;
      done  <= 1'b0;
      ok_r  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= ((state == N_IDLE) && start) ? (vin_max == '0) : (div_end && (idx == 2'd2));
      if ((state == N_IDLE) && start) ok_r <= 1'b0;
      else if (div_end && (idx == 2'd2)) ok_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      N_IDLE: begin
        if (start) begin
          neg <= vin_neg;
          mag <= vin_mag;
          mx  <= vin_max;
          idx <= 2'd0;
          if (vin_max == '0) vout <= '0;
        end
      end
      N_SHIFT: begin
        if (shr) begin
          for (int i = 0; i < 3; i++) mag[i] <= mag[i] >> 1;
          mx <= mx >> 1;
        end else if (shl) begin
          for (int i = 0; i < 3; i++) mag[i] <= mag[i] << 1;
          mx <= mx << 1;
        end
        idx <= 2'd0;
      end
      N_SQ: begin
        prod  <= mag[sq_sel][29:0] * mag[sq_sel][29:0];
        rem_n <= (idx == 2'd0) ? '0 : rem_n + SW'(prod);
        idx   <= idx + 2'd1;
        res   <= '0;
        bitv  <= SW'(1) << 62;
      end
      N_SQRT: begin
        if (take_s) begin
          rem_n <= rem_n - trial_s;
          res   <= (res >> 1) + bitv;
        end else begin
          res <= res >> 1;
        end
        bitv <= bitv >> 2;
        idx  <= 2'd0;
      end
      N_DLOAD: begin
        dvd <= (NDW'(mag[idx]) << FRAC_BITS) + NDW'(res[30:1]);
        rem <= '0;
        quo <= '0;
        cnt <= $bits(cnt)'(NDW - 1);
      end
      N_DIV: begin
        rem <= take_d ? 31'(trial_d - {1'b0, res[30:0]}) : trial_d[30:0];
        quo <= q_new;
        dvd <= dvd << 1;
        cnt <= cnt - 1'b1;
        if (div_end) begin
          vout[idx] <= neg[idx] ? VW'(~q_new + 1'b1) : q_new;
          if (idx != 2'd2) idx <= idx + 2'd1;
        end
      end
      default: ;
    endcase
  end

endmodule

// ----- design/lav_core.sv -----
// Back end: two normalizations, then a shared multiply-accumulate for up and translation.
module lav_core
  import lav_pkg::*;
#(
  parameter int FRAC_BITS = 16
)
(
  input  logic clk,
  input  logic rst,
  input  logic job_valid,
  output logic job_ready,
  input  job_t job,
  output logic load,
  output mat_t mat,
  input  logic free
);

  localparam int VW = FRAC_BITS + 2;
  localparam int UW = FRAC_BITS + 3;
  localparam int PW = UW + 32;
  localparam int AW = PW + 2;
  localparam logic signed [AW-1:0] HALF = AW'(1) <<< (FRAC_BITS - 1);
  localparam logic signed [AW-1:0] SMAX = AW'(32'sh7fff_ffff);
  localparam logic signed [AW-1:0] SMIN = ~SMAX;

  core_state_t state, state_next;

  logic [2:0][31:0]     eye;
  logic [2:0][VW-1:0]   fwd;
  logic [2:0][VW-1:0]   rgt;
  logic [2:0][UW-1:0]   upv;
  logic [2:0][31:0]     trn;
  logic                 degen;
  logic [2:0]           jb;
  logic [1:0]           tm;
  logic signed [PW-1:0] prod;
  logic                 psub;
  logic signed [AW-1:0] acc;

  logic                 norm_start;
  logic [2:0][DW-1:0]   norm_vin;
  norm_sts_t            norm_sts;
  logic [2:0][VW-1:0]   norm_vout;

  logic signed [UW-1:0] opa;
  logic signed [31:0]   opb;
  logic                 osub;
  logic [1:0]           last_tm;
  logic signed [AW-1:0] base;
  logic signed [AW-1:0] rsum;
  logic signed [AW-1:0] rnd;
  logic [31:0]          sat;

  lav_norm #(.FRAC_BITS(FRAC_BITS)) u_norm (
    .clk   (clk),
    .rst   (rst),
    .start (norm_start),
    .vin   (norm_vin),
    .sts   (norm_sts),
    .vout  (norm_vout)
  );

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      C_IDLE:   if (job_valid) state_next = job.zero ? C_WRITE : C_NORM_F;
      C_NORM_F: if (norm_sts.done) state_next = norm_sts.ok ? C_NORM_R : C_WRITE;
      C_NORM_R: if (norm_sts.done) state_next = norm_sts.ok ? C_MUL : C_WRITE;
      C_MUL:    state_next = C_ACC;
      C_ACC:    state_next = (tm == last_tm) ? C_FIN : C_MUL;
      C_FIN:    state_next = (jb == 3'd5) ? C_WRITE : C_MUL;
      C_WRITE:  if (free) state_next = C_IDLE;
      default:  state_next = C_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    job_ready  = (state == C_IDLE);
    norm_start = ((state == C_IDLE) && job_valid && !job.zero) ||
                 ((state == C_NORM_F) && norm_sts.done && norm_sts.ok);
    // second pass takes world-up cross forward: (f.z, 0, -f.x)
    if (state == C_IDLE) begin
      norm_vin = job.diff;
    end else begin
      norm_vin[0] = DW'($signed(norm_vout[2]));
      norm_vin[1] = '0;
      norm_vin[2] = -DW'($signed(norm_vout[0]));
    end
    load = (state == C_WRITE) && free;
    for (int i = 0; i < 3; i++) begin
      mat.rgt[i] = degen ? '0 : 32'($signed(rgt[i]));
      mat.upv[i] = degen ? '0 : 32'($signed(upv[i]));
      mat.fwd[i] = degen ? '0 : 32'($signed(fwd[i]));
      mat.trn[i] = degen ? '0 : trn[i];
    end
    mat.degen = degen;
  end

  // operand select: cross product terms, then negated dot products with eye
  always_comb begin
    opa     = '0;
    opb     = '0;
    osub    = 1'b0;
    last_tm = (jb < 3'd3) ? 2'd1 : 2'd2;
    unique case ({jb, tm})
      {3'd0, 2'd0}: begin opa = UW'($signed(fwd[1])); opb = 32'($signed(rgt[2])); end
      {3'd0, 2'd1}: begin opa = UW'($signed(fwd[2])); opb = 32'($signed(rgt[1])); osub = 1'b1; end
      {3'd1, 2'd0}: begin opa = UW'($signed(fwd[2])); opb = 32'($signed(rgt[0])); end
      {3'd1, 2'd1}: begin opa = UW'($signed(fwd[0])); opb = 32'($signed(rgt[2])); osub = 1'b1; end
      {3'd2, 2'd0}: begin opa = UW'($signed(fwd[0])); opb = 32'($signed(rgt[1])); end
      {3'd2, 2'd1}: begin opa = UW'($signed(fwd[1])); opb = 32'($signed(rgt[0])); osub = 1'b1; end
      {3'd3, 2'd0}: begin opa = UW'($signed(rgt[0])); opb = eye[0]; osub = 1'b1; end
      {3'd3, 2'd1}: begin opa = UW'($signed(rgt[1])); opb = eye[1]; osub = 1'b1; end
      {3'd3, 2'd2}: begin opa = UW'($signed(rgt[2])); opb = eye[2]; osub = 1'b1; end
      {3'd4, 2'd0}: begin opa = upv[0]; opb = eye[0]; osub = 1'b1; end
      {3'd4, 2'd1}: begin opa = upv[1]; opb = eye[1]; osub = 1'b1; end
      {3'd4, 2'd2}: begin opa = upv[2]; opb = eye[2]; osub = 1'b1; end
      {3'd5, 2'd0}: begin opa = UW'($signed(fwd[0])); opb = eye[0]; osub = 1'b1; end
      {3'd5, 2'd1}: begin opa = UW'($signed(fwd[1])); opb = eye[1]; osub = 1'b1; end
      {3'd5, 2'd2}: begin opa = UW'($signed(fwd[2])); opb = eye[2]; osub = 1'b1; end
      default: ;
    endcase
  end

  // round half away from zero: add half, less one when negative, then floor
  always_comb begin
    base = (tm == 2'd0) ? '0 : acc;
    rsum = acc + HALF - AW'(acc[AW-1]);
    rnd  = rsum >>> FRAC_BITS;
    if (rnd > SMAX) begin
      sat = 32'h7fff_ffff;
    end else if (rnd < SMIN) begin
      sat = 32'h8000_0000;
    end else begin
      sat = rnd[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= C_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      C_IDLE: begin
        if (job_valid) begin
          eye   <= job.eye;
          degen <= job.zero;
        end
      end
      C_NORM_F: begin
        if (norm_sts.done) begin
          fwd <= norm_vout;
          if (!norm_sts.ok) degen <= 1'b1;
        end
      end
      C_NORM_R: begin
        if (norm_sts.done) begin
          rgt <= norm_vout;
          jb  <= 3'd0;
          tm  <= 2'd0;
          if (!norm_sts.ok) degen <= 1'b1;
        end
      end
      C_MUL: begin
        prod <= opa * opb;
        psub <= osub;
      end
      C_ACC: begin
        acc <= psub ? base - AW'(prod) : base + AW'(prod);
        if (tm != last_tm) tm <= tm + 2'd1;
      end
      C_FIN: begin
        unique case (jb)
          3'd0:    upv[0] <= rnd[UW-1:0];
          3'd1:    upv[1] <= rnd[UW-1:0];
          3'd2:    upv[2] <= rnd[UW-1:0];
          3'd3:    trn[0] <= sat;
          3'd4:    trn[1] <= sat;
          3'd5:    trn[2] <= sat;
          default: ;
        endcase
        jb <= jb + 3'd1;
        tm <= 2'd0;
      end
      default: ;
    endcase
  end

endmodule

// ----- design/lav_out.sv -----
// Output buffer: holds one matrix and sends it as four row words.
module lav_out
  import lav_pkg::*;
#(
  parameter int FRAC_BITS = 16
)
(
  input  logic               clk,
  input  logic               rst,
  input  logic               load,
  input  mat_t               mat,
  output logic               free,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         row_index,
  output logic signed [31:0] entry_0,
  output logic signed [31:0] entry_1,
  output logic signed [31:0] entry_2,
  output logic signed [31:0] entry_3,
  output logic               last_row,
  output logic               degenerate
);

  localparam logic [31:0] ONE = 32'(1) << FRAC_BITS;

  logic       busy;
  logic [1:0] row;
  mat_t       m;

  assign free       = !busy;
  assign out_valid  = busy;
  assign row_index  = row;
  assign last_row   = (row == 2'd3);
  assign degenerate = m.degen;

  always_comb begin
    unique case (row)
      2'd0: begin entry_0 = m.rgt[0]; entry_1 = m.upv[0]; entry_2 = m.fwd[0]; end
      2'd1: begin entry_0 = m.rgt[1]; entry_1 = m.upv[1]; entry_2 = m.fwd[1]; end
      2'd2: begin entry_0 = m.rgt[2]; entry_1 = m.upv[2]; entry_2 = m.fwd[2]; end
      2'd3: begin entry_0 = m.trn[0]; entry_1 = m.trn[1]; entry_2 = m.trn[2]; end
      default: begin entry_0 = '0; entry_1 = '0; entry_2 = '0; end
    endcase
    entry_3 = (last_row && !m.degen) ? ONE : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      row  <= 2'd0;
    end else if (load) begin
      busy <= 1'b1;
      row  <= 2'd0;
    end else if (busy && out_ready) begin
      if (last_row) busy <= 1'b0;
      row <= row + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      m <= mat;
    end
  end

`ifndef SYNTH
  a_load_free: assert property (@(posedge clk) disable iff (rst) load |-> free)
    else $error("matrix loaded while previous one still sending");
  a_row_step: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_ready && !last_row) |=>
    (out_valid && (row_index == $past(row_index) + 2'd1)))
    else $error("row sequence broken");
  a_row_wrap: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_ready && last_row) |=> (row_index == 2'd0))
    else $error("row counter did not return to zero");
  a_degen_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && degenerate) |-> (entry_0 == '0 && entry_1 == '0 && entry_3 == '0))
    else $error("degenerate word carries nonzero entries");
`endif

endmodule

// ----- design/look_at_view_matrix.sv -----
// Top level of the look-at view matrix generator.
//
// Input channel (in_valid/in_ready): one word holds eye and target, three
// signed Q16.16 coordinates each. Output channel (out_valid/out_ready): each
// input word yields four row words, row_index 0..3, last_row on row 3.
// Rows 0..2 carry right, up and forward components; row 3 carries the
// negated dot products of the basis with eye, then 1.0.
// degenerate is set on all four rows when eye equals target or the view is
// parallel to world up; the entries are then zero.
// Most of the work per word is done in the normalize unit, which runs twice
// per word and does a one-bit-per-cycle square root (32 steps) and three
// one-bit-per-cycle divides (31+FRAC_BITS steps each). The cross products
// and dot products run on one shared multiplier.
// The front stage and a two-entry queue keep accepting words while the back
// end computes; a finished matrix sits in the output buffer so the next word
// can start. When the receiver stalls, rows hold, the buffer stays full and
// the back end, then the queue and the front, fill and drop in_ready.
// Reset (synchronous, active high) empties all stages.
module look_at_view_matrix
  import lav_pkg::*;
#(
  parameter int FRAC_BITS = 16
)
(
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [31:0] eye_x,
  input  logic signed [31:0] eye_y,
  input  logic signed [31:0] eye_z,
  input  logic signed [31:0] target_x,
  input  logic signed [31:0] target_y,
  input  logic signed [31:0] target_z,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         row_index,
  output logic signed [31:0] entry_0,
  output logic signed [31:0] entry_1,
  output logic signed [31:0] entry_2,
  output logic signed [31:0] entry_3,
  output logic               last_row,
  output logic               degenerate
);

  // front to queue
  logic fq_valid;
  logic fq_ready;
  job_t fq_data;

  // queue to back end
  logic qc_valid;
  logic qc_ready;
  job_t qc_data;

  // back end to output buffer
  logic load;
  logic free;
  mat_t mat;

  lav_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .eye_x    (eye_x),
    .eye_y    (eye_y),
    .eye_z    (eye_z),
    .target_x (target_x),
    .target_y (target_y),
    .target_z (target_z),
    .q_valid  (fq_valid),
    .q_ready  (fq_ready),
    .q_data   (fq_data)
  );

  lav_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_valid (fq_valid),
    .wr_ready (fq_ready),
    .wr_data  (fq_data),
    .rd_valid (qc_valid),
    .rd_ready (qc_ready),
    .rd_data  (qc_data)
  );

  lav_core #(.FRAC_BITS(FRAC_BITS)) u_core (
    .clk       (clk),
    .rst       (rst),
    .job_valid (qc_valid),
    .job_ready (qc_ready),
    .job       (qc_data),
    .load      (load),
    .mat       (mat),
    .free      (free)
  );

  lav_out #(.FRAC_BITS(FRAC_BITS)) u_out (
    .clk        (clk),
    .rst        (rst),
    .load       (load),
    .mat        (mat),
    .free       (free),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .row_index  (row_index),
    .entry_0    (entry_0),
    .entry_1    (entry_1),
    .entry_2    (entry_2),
    .entry_3    (entry_3),
    .last_row   (last_row),
    .degenerate (degenerate)
  );

endmodule

// ----- sim/tb_look_at_view_matrix.sv -----
// Testbench for the look-at view matrix generator: scoreboard plus drivers.
`timescale 1ns / 1ps

module tb_look_at_view_matrix;
  import lav_pkg::*;

  localparam int FB       = 16;     // fraction bits of the block under test
  localparam int WD_LIMIT = 30000;  // cycles with no word moving before giving up

  typedef struct packed {
    logic [1:0]  idx;
    logic [31:0] e0;
    logic [31:0] e1;
    logic [31:0] e2;
    logic [31:0] e3;
    logic        last;
    logic        deg;
  } row_word_t;

  // Scoreboard: turns an accepted eye/target word into its four matrix rows
  // and checks output rows against them in order.
  class matrix_board;
    row_word_t rows_due[$];
    int        mismatches;
    int        rows_seen;
    int        words_in;
    int        degen_words;

    function longint unsigned sqrt_floor(longint unsigned n);
      longint unsigned res;
      longint unsigned b;
      res = 0;
      b = 64'd1 << 62;
      while (b > n) b = b >> 2;
      while (b != 0) begin
        if (n >= res + b) begin
          n = n - (res + b);
          res = (res >> 1) + b;
        end else begin
          res = res >> 1;
        end
        b = b >> 2;
      end
      return res;
    endfunction

    // shift right by FB, rounding half away from zero
    function longint shr_round(longint v);
      longint unsigned m;
      m = (v < 0) ? -v : v;
      m = (m + (64'd1 << (FB - 1))) >> FB;
      return (v < 0) ? -longint'(m) : longint'(m);
    endfunction

    function longint clamp32(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
    endfunction

    // unit vector in Q(FB); 0 for a zero vector
    function bit unit_vec(input longint v[3], output longint o[3]);
      longint unsigned mag[3];
      bit              sgn[3];
      longint unsigned mx, sum, len, q;
      mx = 0;
      sum = 0;
      for (int i = 0; i < 3; i++) begin
        sgn[i] = v[i] < 0;
        mag[i] = sgn[i] ? -v[i] : v[i];
        if (mag[i] > mx) mx = mag[i];
      end
      if (mx == 0) begin
        for (int i = 0; i < 3; i++) o[i] = 0;
        return 0;
      end
      while (mx >= (64'd1 << 30)) begin
        for (int i = 0; i < 3; i++) mag[i] = mag[i] >> 1;
        mx = mx >> 1;
      end
      while (mx < (64'd1 << 29)) begin
        for (int i = 0; i < 3; i++) mag[i] = mag[i] << 1;
        mx = mx << 1;
      end
      for (int i = 0; i < 3; i++) sum += mag[i] * mag[i];
      len = sqrt_floor(sum);
      for (int i = 0; i < 3; i++) begin
        q = ((mag[i] << FB) + len / 2) / len;
        o[i] = sgn[i] ? -longint'(q) : longint'(q);
      end
      return 1;
    endfunction

    function void note_word(logic signed [31:0] ex, ey, ez, tx, ty, tz);
      longint    eye[3], d[3], f[3], rr[3], r[3], u[3];
      longint    m[4][4];
      bit        ok;
      row_word_t w;
      eye[0] = longint'(ex); eye[1] = longint'(ey); eye[2] = longint'(ez);
      d[0] = longint'(ex) - longint'(tx);
      d[1] = longint'(ey) - longint'(ty);
      d[2] = longint'(ez) - longint'(tz);
      ok = unit_vec(d, f);
      rr[0] = f[2];
      rr[1] = 0;
      rr[2] = -f[0];
      if (!unit_vec(rr, r)) ok = 0;
      u[0] = shr_round(f[1] * r[2] - f[2] * r[1]);
      u[1] = shr_round(f[2] * r[0] - f[0] * r[2]);
      u[2] = shr_round(f[0] * r[1] - f[1] * r[0]);
      for (int i = 0; i < 3; i++) begin
        m[i][0] = r[i];
        m[i][1] = u[i];
        m[i][2] = f[i];
        m[i][3] = 0;
      end
      m[3][0] = clamp32(shr_round(-(r[0] * eye[0] + r[1] * eye[1] + r[2] * eye[2])));
      m[3][1] = clamp32(shr_round(-(u[0] * eye[0] + u[1] * eye[1] + u[2] * eye[2])));
      m[3][2] = clamp32(shr_round(-(f[0] * eye[0] + f[1] * eye[1] + f[2] * eye[2])));
      m[3][3] = 64'sd1 << FB;
      words_in++;
      if (!ok) degen_words++;
      for (int k = 0; k < 4; k++) begin
        w.idx  = 2'(k);
        w.e0   = ok ? m[k][0][31:0] : '0;
        w.e1   = ok ? m[k][1][31:0] : '0;
        w.e2   = ok ? m[k][2][31:0] : '0;
        w.e3   = ok ? m[k][3][31:0] : '0;
        w.last = (k == 3);
        w.deg  = !ok;
        rows_due.push_back(w);
      end
    endfunction

    function void flag(string what, row_word_t want, row_word_t got);
      mismatches++;
      if (mismatches <= 10)
        $display({"MISMATCH %s: exp idx=%0d e=%h %h %h %h last=%b deg=%b",
                  " | got idx=%0d e=%h %h %h %h last=%b deg=%b"},
                 what, want.idx, want.e0, want.e1, want.e2, want.e3, want.last, want.deg,
                 got.idx, got.e0, got.e1, got.e2, got.e3, got.last, got.deg);
    endfunction

    function void check_row(row_word_t got);
      row_word_t want;
      rows_seen++;
      if (rows_due.size() == 0) begin
        flag("unexpected row", '0, got);
        return;
      end
      want = rows_due.pop_front();
      if (got !== want) flag("row", want, got);
    endfunction
  endclass

  logic               clk = 0;
  logic               rst = 1;
  logic               in_valid = 0;
  logic               in_ready;
  logic signed [31:0] eye_x = 0, eye_y = 0, eye_z = 0;
  logic signed [31:0] target_x = 0, target_y = 0, target_z = 0;
  logic               out_valid;
  logic               out_ready = 0;
  logic [1:0]         row_index;
  logic signed [31:0] entry_0, entry_1, entry_2, entry_3;
  logic               last_row, degenerate;

  matrix_board board = new();
  int  idle_cycles = 0;
  bit  rx_no_stall = 0;  // receiver stays ready for a stretch

  look_at_view_matrix #(.FRAC_BITS(FB)) dut (.*);

  initial begin
    forever #10 clk = ~clk;
  end

  // short gaps mostly, a few long ones
  function int pick_gap();
    if ($urandom_range(0, 9) < 7) return $urandom_range(0, 2);
    if ($urandom_range(0, 3) < 3) return $urandom_range(3, 20);
    return $urandom_range(50, 300);
  endfunction

  // Monitor: everything sampled at the rising edge.
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready)
        board.note_word(eye_x, eye_y, eye_z, target_x, target_y, target_z);
      if (out_valid && out_ready)
        board.check_row({row_index, entry_0, entry_1, entry_2, entry_3, last_row,
                         degenerate});
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
    end
  end

  // Watchdog: ends the run when nothing has moved for too long.
  initial begin
    wait (idle_cycles >= WD_LIMIT);
    $display("watchdog: no word moved for %0d cycles", WD_LIMIT);
    $display("tb_look_at_view_matrix: done, errors");
    $finish;
  end

  // Receiver: ready toggles at the falling edge, with random stalls.
  initial begin
    int n;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      out_ready = 1;
      n = rx_no_stall ? 40 : $urandom_range(1, 12);
      repeat (n) @(negedge clk);
      if (!rx_no_stall) begin
        out_ready = 0;
        n = pick_gap();
        repeat (n) @(negedge clk);
      end
    end
  end

  // Send one word; called and returns at a falling edge.
  task automatic send_word(logic [31:0] ex, ey, ez, tx, ty, tz, bit gaps);
    int g;
    in_valid = 1;
    eye_x = ex; eye_y = ey; eye_z = ez;
    target_x = tx; target_y = ty; target_z = tz;
    while (!in_ready) @(negedge clk);
    @(negedge clk);  // accepted at the rising edge just passed
    g = gaps ? pick_gap() : 0;
    if (g > 0) begin
      in_valid = 0;
      repeat (g) @(negedge clk);
    end
  endtask

  function logic [31:0] small_coord();
    return $signed($urandom_range(0, 20 << 16)) - (10 << 16);
  endfunction

  task automatic send_random(bit gaps);
    logic [31:0] v[6];
    int          kind;
    kind = $urandom_range(0, 19);
    for (int i = 0; i < 6; i++) v[i] = (kind < 12) ? small_coord() : $urandom();
    if (kind == 18) begin
      // eye on target
      v[3] = v[0]; v[4] = v[1]; v[5] = v[2];
    end else if (kind == 19) begin
      // looking straight along world up, maybe with a tiny side offset
      v[3] = v[0] + $urandom_range(0, 1);
      v[5] = v[2] - $urandom_range(0, 1);
    end
    send_word(v[0], v[1], v[2], v[3], v[4], v[5], gaps);
  endtask

  initial begin
    bit gaps;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 0;

    // directed words
    send_word(0, 0, 0, 0, 0, 0, 1);                                  // eye on target
    send_word(32'h0001_0000, 32'h0005_0000, 32'h0002_0000,
              32'h0001_0000, 32'h0005_0000, 32'h0002_0000, 1);       // eye on target
    send_word(0, 32'h0005_0000, 0, 0, 0, 0, 1);                      // straight down
    send_word(0, 0, 0, 0, 32'h0005_0000, 0, 1);                      // straight up
    send_word(1, 32'h4000_0000, 0, 0, 0, 0, 1);                      // side lost in scaling
    send_word(0, 0, 32'h0001_0000, 0, 0, 0, 1);                      // plain +z view
    send_word(32'h0003_0000, 32'h0002_0000, 32'h0004_0000, 0, 0, 0, 0);
    send_word(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
              32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 0);       // widest difference
    send_word(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
              32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 0);
    send_word(32'h7fff_ffff, 0, 32'h8000_0000, 0, 32'h7fff_ffff, 0, 1);  // saturating translation
    send_word(32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff, 0, 0, 0, 1);
    send_word(1, 0, 0, 0, 0, 0, 1);                                  // one-lsb difference
    send_word(0, 0, 0, 0, 0, 1, 1);
    send_word(32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 0, 0, 0, 1);
    send_word(32'h0001_0000, 32'h0001_0000, 32'h0001_0000,
              32'h0001_0001, 32'h0001_0000, 32'h0001_0000, 0);
    send_word(32'h0000_8000, 32'hffff_8000, 32'h0000_8000, 0, 0, 0, 0);  // rounding halves
    in_valid = 0;

    // hold off until every expected row is back
    while (board.rows_due.size() != 0) @(negedge clk);

    for (int n = 0; n < 154; n++) begin
      // alternate stretches with and without idling
      gaps = ((n / 25) % 3) != 2;
      rx_no_stall = !gaps;
      send_random(gaps);
      if (n == 90) begin
        in_valid = 0;
        while (board.rows_due.size() != 0) @(negedge clk);
      end
    end
    in_valid = 0;
    rx_no_stall = 1;

    while (board.rows_due.size() != 0) @(negedge clk);
    repeat (600) @(negedge clk);

    $display("covered %0d words (%0d degenerate), %0d rows checked, %0d mismatches",
             board.words_in, board.degen_words, board.rows_seen, board.mismatches);
    if (board.mismatches == 0 && board.rows_due.size() == 0) begin
      $display("tb_look_at_view_matrix: done, clean");
    end else begin
      $display("tb_look_at_view_matrix: done, errors");
    end
    $finish;
  end

endmodule
